>>> hw/rtl/prbc_pkg.sv
// Shared types, widths and register codes for the polyline rectangle border crossing block.
package prbc_pkg;

   // Coordinate width of vertices and rectangle position
   localparam int COORD_BITS = 16;
   // Widths of the rectangle size registers
   localparam int SIZE_BITS  = COORD_BITS - 1;
   // Right and bottom edges need one more bit than a coordinate
   localparam int EDGE_BITS  = COORD_BITS + 1;
   // Differences between a corner and a vertex
   localparam int DIFF_BITS  = COORD_BITS + 2;
   // Full cross-product term
   localparam int PROD_BITS  = 2 * DIFF_BITS;

   // Depth of the queue between front and back
   localparam int QUEUE_DEPTH = 4;
   localparam int PTR_BITS    = $clog2(QUEUE_DEPTH);
   localparam int COUNT_BITS  = $clog2(QUEUE_DEPTH + 1);

   // Configuration register indexes
   localparam int CSR_INDEX_BITS = 2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_RECT_LEFT   = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_RECT_TOP    = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_RECT_WIDTH  = 2'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_RECT_HEIGHT = 2'd3;

   // Input item
   typedef struct packed {
      logic signed [COORD_BITS-1:0] vertex_x;
      logic signed [COORD_BITS-1:0] vertex_y;
      logic                         vertex_last;
   } req_item_type;

   // Result item
   typedef struct packed {
      logic edge_hit;
      logic any_hit;
      logic result_last;
   } rsp_item_type;

   // One polyline edge waiting for the back end
   typedef struct packed {
      logic signed [COORD_BITS-1:0] ax;
      logic signed [COORD_BITS-1:0] ay;
      logic signed [COORD_BITS-1:0] bx;
      logic signed [COORD_BITS-1:0] by;
      logic                         have_prev;
      logic                         last;
   } edge_item_type;

   // Rectangle as seen by the back end
   typedef struct packed {
      logic signed [COORD_BITS-1:0] left;
      logic signed [COORD_BITS-1:0] top;
      logic signed [EDGE_BITS-1:0]  right;
      logic signed [EDGE_BITS-1:0]  bottom;
      logic                         width_nz;
      logic                         height_nz;
   } rect_cfg_type;

   // Sign-extend a coordinate to the difference width
   function automatic logic signed [DIFF_BITS-1:0] ext_coord(
      input logic signed [COORD_BITS-1:0] v);
      return {{(DIFF_BITS-COORD_BITS){v[COORD_BITS-1]}}, v};
   endfunction

   // Sign-extend a right or bottom edge to the difference width
   function automatic logic signed [DIFF_BITS-1:0] ext_edge(
      input logic signed [EDGE_BITS-1:0] v);
      return {{(DIFF_BITS-EDGE_BITS){v[EDGE_BITS-1]}}, v};
   endfunction

endpackage

>>> hw/rtl/prbc_front.sv
// Front end: accepts vertices, keeps the previous vertex and forms one edge per item.
module prbc_front
   import prbc_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  req_item_type  req_item,
   input  logic          q_full,
   output logic          q_push,
   output edge_item_type q_item
);

   logic signed [COORD_BITS-1:0] prev_x_ff, prev_x_in;
   logic signed [COORD_BITS-1:0] prev_y_ff, prev_y_in;
   logic                         have_prev_ff, have_prev_in;

   // Accept whenever the queue has room
   assign req_ready = !q_full;
   assign q_push    = req_valid && req_ready;

   // Edge from the stored vertex to the new one
   always_comb begin
      q_item.ax        = prev_x_ff;
      q_item.ay        = prev_y_ff;
      q_item.bx        = req_item.vertex_x;
      q_item.by        = req_item.vertex_y;
      q_item.have_prev = have_prev_ff;
      q_item.last      = req_item.vertex_last;
   end

   // Previous vertex; a last vertex ends the polyline
   always_comb begin
      prev_x_in    = prev_x_ff;
      prev_y_in    = prev_y_ff;
      have_prev_in = have_prev_ff;
      if (q_push) begin
         prev_x_in    = req_item.vertex_x;
         prev_y_in    = req_item.vertex_y;
         have_prev_in = !req_item.vertex_last;
      end
   end

   always_ff @(posedge clock) begin
      prev_x_ff <= prev_x_in;
      prev_y_ff <= prev_y_in;
      if (reset) begin
         have_prev_ff <= 1'b0;
      end else begin
         have_prev_ff <= have_prev_in;
      end
   end

endmodule

>>> hw/rtl/prbc_queue.sv
// Short queue of edges between the front and back ends.
module prbc_queue
   import prbc_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          push,
   input  edge_item_type push_item,
   output logic          full,
   input  logic          pop,
   output logic          head_valid,
   output edge_item_type head_item
);

   edge_item_type           slot_ff [QUEUE_DEPTH];
   logic [PTR_BITS-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [COUNT_BITS-1:0]   count_ff, count_in;
   logic                    do_push, do_pop;

   assign full       = (count_ff == COUNT_BITS'(QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_item  = slot_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   // Pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Fill count never passes the depth
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= COUNT_BITS'(QUEUE_DEPTH))
      else $error("queue fill count above depth");

endmodule

>>> hw/rtl/prbc_back.sv
// Back end: orientation tests of each edge against the rectangle border, and result output.
module prbc_back
   import prbc_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  rect_cfg_type  rect,
   input  logic          head_valid,
   input  edge_item_type head_item,
   output logic          pop,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   output rsp_item_type  rsp_item
);

   localparam int NCORNER = 4;

   // Corners in order: left-top, right-top, right-bottom, left-bottom
   logic signed [DIFF_BITS-1:0] corner_x [NCORNER];
   logic signed [DIFF_BITS-1:0] corner_y [NCORNER];
   logic signed [DIFF_BITS-1:0] ax_w, ay_w, bx_w, by_w;
   logic [NCORNER-1:0]          side_a, side_b;

   // Stage 1: differences and rectangle-side orientations
   logic                        v1_ff, v1_in;
   logic signed [DIFF_BITS-1:0] ex_ff, ey_ff;
   logic signed [DIFF_BITS-1:0] cx_ff [NCORNER];
   logic signed [DIFF_BITS-1:0] cy_ff [NCORNER];
   logic [NCORNER-1:0]          xr1_ff;
   logic                        have1_ff, last1_ff;

   // Stage 2: cross-product terms
   logic                        v2_ff, v2_in;
   logic signed [PROD_BITS-1:0] pl_ff [NCORNER];
   logic signed [PROD_BITS-1:0] pr_ff [NCORNER];
   logic [NCORNER-1:0]          xr2_ff;
   logic                        have2_ff, last2_ff;

   // Output register and running hit
   logic                        rsp_valid_ff, rsp_valid_in;
   rsp_item_type                rsp_item_ff;
   logic                        acc_ff, acc_in;

   logic                        adv_out, adv2, adv1, load_out;
   logic [NCORNER-1:0]          ob, ob_next;
   logic                        hit, any;

   // Stall chain: a stage moves when the next one is empty or moving
   assign adv_out  = !rsp_valid_ff || rsp_ready;
   assign adv2     = !v2_ff || adv_out;
   assign adv1     = !v1_ff || adv2;
   assign pop      = head_valid && adv1;
   assign load_out = v2_ff && adv_out;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

   // Rectangle corners
   always_comb begin
      corner_x[0] = ext_coord(rect.left);
      corner_y[0] = ext_coord(rect.top);
      corner_x[1] = ext_edge(rect.right);
      corner_y[1] = ext_coord(rect.top);
      corner_x[2] = ext_edge(rect.right);
      corner_y[2] = ext_edge(rect.bottom);
      corner_x[3] = ext_coord(rect.left);
      corner_y[3] = ext_edge(rect.bottom);
   end

   assign ax_w = ext_coord(head_item.ax);
   assign ay_w = ext_coord(head_item.ay);
   assign bx_w = ext_coord(head_item.bx);
   assign by_w = ext_coord(head_item.by);

   // Orientation of a vertex against each border edge reduces to a sign test,
   // since the border edges are axis-aligned
   always_comb begin
      side_a[0] = rect.width_nz  && (ay_w > corner_y[0]);
      side_a[1] = rect.height_nz && (ax_w < corner_x[1]);
      side_a[2] = rect.width_nz  && (ay_w < corner_y[2]);
      side_a[3] = rect.height_nz && (ax_w > corner_x[3]);
      side_b[0] = rect.width_nz  && (by_w > corner_y[0]);
      side_b[1] = rect.height_nz && (bx_w < corner_x[1]);
      side_b[2] = rect.width_nz  && (by_w < corner_y[2]);
      side_b[3] = rect.height_nz && (bx_w > corner_x[3]);
   end

   assign v1_in = adv1 ? head_valid : v1_ff;
   assign v2_in = adv2 ? v1_ff : v2_ff;

   // Stage 1 registers
   always_ff @(posedge clock) begin
      if (pop) begin
         ex_ff    <= bx_w - ax_w;
         ey_ff    <= by_w - ay_w;
         xr1_ff   <= side_a ^ side_b;
         have1_ff <= head_item.have_prev;
         last1_ff <= head_item.last;
         for (int k = 0; k < NCORNER; k++) begin
            cx_ff[k] <= corner_x[k] - ax_w;
            cy_ff[k] <= corner_y[k] - ay_w;
         end
      end
   end

   // Stage 2 registers: one product pair per corner
   always_ff @(posedge clock) begin
      if (adv2 && v1_ff) begin
         xr2_ff   <= xr1_ff;
         have2_ff <= have1_ff;
         last2_ff <= last1_ff;
         for (int k = 0; k < NCORNER; k++) begin
            pl_ff[k] <= ex_ff * cy_ff[k];
            pr_ff[k] <= ey_ff * cx_ff[k];
         end
      end
   end

   // Edge orientation per corner, then border edge e spans corners e and e+1
   always_comb begin
      for (int k = 0; k < NCORNER; k++) begin
         ob[k] = pl_ff[k] > pr_ff[k];
      end
      ob_next = {ob[0], ob[NCORNER-1:1]};
      hit     = have2_ff && (|((ob ^ ob_next) & xr2_ff));
      any     = acc_ff || hit;
   end

   // Running hit clears at the end of a polyline
   always_comb begin
      acc_in       = acc_ff;
      rsp_valid_in = rsp_valid_ff;
      if (load_out) begin
         acc_in       = last2_ff ? 1'b0 : any;
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load_out) begin
         rsp_item_ff.edge_hit    <= hit;
         rsp_item_ff.any_hit     <= any;
         rsp_item_ff.result_last <= last2_ff;
      end
      if (reset) begin
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
         acc_ff       <= 1'b0;
      end else begin
         v1_ff        <= v1_in;
         v2_ff        <= v2_in;
         rsp_valid_ff <= rsp_valid_in;
         acc_ff       <= acc_in;
      end
   end

   // A hit on this edge is always part of the running hit
   a_edge_in_any: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (!rsp_item_ff.edge_hit || rsp_item_ff.any_hit))
      else $error("edge hit without running hit");

   // The running hit starts afresh after a last vertex
   a_acc_clear: assert property (@(posedge clock) disable iff (reset)
      (load_out && last2_ff) |=> !acc_ff)
      else $error("running hit not cleared after last vertex");

   // A product pair held back by the output is not lost
   a_stage2_hold: assert property (@(posedge clock) disable iff (reset)
      (v2_ff && !adv_out) |=> v2_ff)
      else $error("stalled product stage dropped");

endmodule

>>> hw/rtl/polyline_rect_border_cross.sv
// Top level of the polyline rectangle border crossing block: configuration registers and wiring.
// Vertices of an open polyline enter one item per cycle on the req_ channel while req_ready
// is high, and every vertex gives one result item on the rsp_ channel: edge_hit for the edge
// from the previous vertex (0 for the first vertex), any_hit for the polyline so far, and
// result_last, on which any_hit is the answer for the whole polyline. Touching and collinear
// contact does not count as a crossing. The sustained rate is one item per clock while
// rsp_ready stays high; a result passes the queue slot, the difference stage, the product
// stage with the eight cross-product multipliers working on all four rectangle corners side
// by side, and the output register. A four-item queue ahead of the three stages lets the
// input keep flowing while results are stalled; the input stalls once seven items are held,
// and a full queue takes no new item in the cycle it hands one on. The user writes the
// rectangle registers through the csr_ port only while no item is in flight; the block does not enforce this.
module polyline_rect_border_cross
   import prbc_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  req_item_type              req_item,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output rsp_item_type              rsp_item,
   input  logic                      csr_write_en,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [COORD_BITS-1:0]     csr_wdata
);

   logic signed [COORD_BITS-1:0] rect_left_ff, rect_left_in;
   logic signed [COORD_BITS-1:0] rect_top_ff, rect_top_in;
   logic [SIZE_BITS-1:0]         rect_width_ff, rect_width_in;
   logic [SIZE_BITS-1:0]         rect_height_ff, rect_height_in;
   rect_cfg_type                 rect_ff, rect_in;

   logic          q_full, q_push, q_pop, q_head_valid;
   edge_item_type q_item, q_head_item;

   // Register write decode
   always_comb begin
      rect_left_in   = rect_left_ff;
      rect_top_in    = rect_top_ff;
      rect_width_in  = rect_width_ff;
      rect_height_in = rect_height_ff;
      if (csr_write_en) begin
         unique case (csr_index)
            CSR_RECT_LEFT:   rect_left_in   = csr_wdata;
            CSR_RECT_TOP:    rect_top_in    = csr_wdata;
            CSR_RECT_WIDTH:  rect_width_in  = csr_wdata[SIZE_BITS-1:0];
            CSR_RECT_HEIGHT: rect_height_in = csr_wdata[SIZE_BITS-1:0];
            default: ;
         endcase
      end
   end

   // Right and bottom edges, worked out once from the registers
   always_comb begin
      rect_in.left      = rect_left_ff;
      rect_in.top       = rect_top_ff;
      rect_in.right     = EDGE_BITS'(rect_left_ff) + EDGE_BITS'({1'b0, rect_width_ff});
      rect_in.bottom    = EDGE_BITS'(rect_top_ff) + EDGE_BITS'({1'b0, rect_height_ff});
      rect_in.width_nz  = (rect_width_ff != '0);
      rect_in.height_nz = (rect_height_ff != '0);
   end

   always_ff @(posedge clock) begin
      rect_ff <= rect_in;
      if (reset) begin
         rect_left_ff   <= '0;
         rect_top_ff    <= '0;
         rect_width_ff  <= '0;
         rect_height_ff <= '0;
      end else begin
         rect_left_ff   <= rect_left_in;
         rect_top_ff    <= rect_top_in;
         rect_width_ff  <= rect_width_in;
         rect_height_ff <= rect_height_in;
      end
   end

   prbc_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_item  (req_item),
      .q_full    (q_full),
      .q_push    (q_push),
      .q_item    (q_item)
   );

   prbc_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_item  (q_item),
      .full       (q_full),
      .pop        (q_pop),
      .head_valid (q_head_valid),
      .head_item  (q_head_item)
   );

   prbc_back u_back (
      .clock      (clock),
      .reset      (reset),
      .rect       (rect_ff),
      .head_valid (q_head_valid),
      .head_item  (q_head_item),
      .pop        (q_pop),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_item   (rsp_item)
   );

endmodule
